// File: design/tprd_pkg.sv
`default_nettype none

package tprd_pkg;

  localparam int unsigned FrameLen  = 14;
  localparam int unsigned RecordLen = 7;
  localparam int unsigned DataBytes = 12;
  localparam int unsigned SlotCount = 6;
  localparam int unsigned WordCount = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [3:0] HdrPos0  = 4'd0;
  localparam logic [3:0] HdrPos1  = 4'(RecordLen);
  localparam logic [3:0] AddrPos0 = 4'(RecordLen - 1);
  localparam logic [3:0] LastPos  = 4'(FrameLen - 1);
  localparam logic [3:0] FramePos = 4'(FrameLen);

  localparam logic [7:0] AddrOne = 8'd1;
  localparam logic [7:0] AddrTwo = 8'd2;

  localparam logic [2:0] SecondRecordWord = 3'd3;
  localparam logic [2:0] LastWord         = 3'(WordCount - 1);

  localparam logic [15:0] ScaleReset = 16'd1152;

  // record bytes without the address bytes, plus the two address flags
  typedef struct packed {
    logic [DataBytes-1:0][6:0] data;
    logic                      hi1;
    logic                      hi2;
  } frame_t;

endpackage

`default_nettype wire

// File: design/tracker_position_record_deframer.sv
// tracker position record deframer
// s_axis carries one received serial byte per item, bit 7 being the phasing bit.
// fourteen bytes make a frame of two seven-byte records, each closed by a
// sensor address of 1 or 2. a framing error drops the partial frame or the
// stray byte, as the frame rules say.
// a complete frame gives one item on m_axis: the six stored positions, signed
// with 16 fractional bits, scaled by the gain written through cfg_we/cfg_wdata.
// throughput: one byte per cycle, sustained, but for the stall below. a frame
// is queued after its last byte, then popped, scaled and shown; the six
// products share one 17x16 multiplier, one word per cycle.
// a two-frame queue sits between framing and scaling, so input keeps flowing
// while m_axis is stalled; only the last byte of a frame waits when the queue
// is full and the receiver still holds off.
// reset clears the frame position, the queue and all six slots, and loads the
// gain with 1152.
`default_nettype none

module tracker_position_record_deframer (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rx_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // slot1_x, slot1_y, slot1_z, slot2_x, slot2_y, slot2_z
  output logic [191:0]      m_axis_tdata
);

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  tprd_pkg::frame_t push_frame;
  tprd_pkg::frame_t head;
  logic [tprd_pkg::SlotCount-1:0][31:0] slots;

  tprd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .q_full     (q_full),
    .push       (q_push),
    .push_frame (push_frame)
  );

  tprd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_frame (push_frame),
    .pop        (q_pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  tprd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .slots     (slots)
  );

  assign m_axis_tdata = slots;

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("frame pushed into full queue");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_full)
    else $error("input stalled without full queue");

  a_pop_starts_run: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !m_axis_tvalid)
    else $error("result shown before scaling ran");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: design/tprd_front.sv
`default_nettype none

module tprd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             q_full,
  output logic                  push,
  output tprd_pkg::frame_t      push_frame
);

  logic [3:0] byte_position;
  logic [3:0] byte_position_next;
  logic [tprd_pkg::DataBytes-1:0][6:0] rec_data;
  logic rec_hi1;

  logic       accept;
  logic [3:0] pos;
  logic       hdr;
  logic       is_hdr_pos;
  logic       is_addr_pos;
  logic       addr_ok;
  logic       store;
  logic [3:0] widx;

  assign in_ready = !((byte_position == tprd_pkg::LastPos) && q_full);
  assign accept   = in_valid && in_ready;
  assign pos      = (byte_position >= tprd_pkg::FramePos) ? tprd_pkg::HdrPos0 : byte_position;
  assign hdr      = in_byte[7];
  assign is_hdr_pos  = (pos == tprd_pkg::HdrPos0) || (pos == tprd_pkg::HdrPos1);
  assign is_addr_pos = (pos == tprd_pkg::AddrPos0) || (pos == tprd_pkg::LastPos);
  assign addr_ok     = (in_byte == tprd_pkg::AddrOne) || (in_byte == tprd_pkg::AddrTwo);
  // address byte of the first record takes no data slot
  assign widx = (pos < tprd_pkg::AddrPos0) ? pos : pos - 4'd1;

  always_comb begin
    byte_position_next = byte_position;
    store = 1'b0;
    push  = 1'b0;
    if (accept) begin
      priority if (is_hdr_pos && !hdr) begin
        byte_position_next = tprd_pkg::HdrPos0;
      end else if (!is_hdr_pos && hdr) begin
        byte_position_next = pos;
      end else if (is_addr_pos && !addr_ok) begin
        byte_position_next = tprd_pkg::HdrPos0;
      end else if (pos != tprd_pkg::LastPos) begin
        store = 1'b1;
        byte_position_next = pos + 4'd1;
      end else begin
        push = 1'b1;
        byte_position_next = tprd_pkg::HdrPos0;
      end
    end
  end

  always_comb begin
    push_frame.data = rec_data;
    push_frame.hi1  = rec_hi1;
    push_frame.hi2  = in_byte[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= tprd_pkg::HdrPos0;
    end else begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store && (pos == tprd_pkg::AddrPos0)) begin
      rec_hi1 <= in_byte[1];
    end else if (store) begin
      rec_data[widx] <= in_byte[6:0];
    end
  end

endmodule

`default_nettype wire

// File: design/tprd_queue.sv
`default_nettype none

module tprd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tprd_pkg::frame_t push_frame,
  input  wire logic             pop,
  output tprd_pkg::frame_t      head,
  output logic                  full,
  output logic                  empty
);

  tprd_pkg::frame_t entries [tprd_pkg::QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'(tprd_pkg::QueueDepth));
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

`default_nettype wire

// File: design/tprd_back.sv
`default_nettype none

module tprd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_wdata,
  input  wire logic             q_empty,
  input  wire tprd_pkg::frame_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [tprd_pkg::SlotCount-1:0][31:0] slots
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    EMIT
  } state_t;

  state_t           state;
  tprd_pkg::frame_t cur;
  logic [2:0]       cnt;
  logic [15:0]      scale;

  logic [6:0]         even_b;
  logic [6:0]         odd_b;
  logic signed [15:0] word;
  logic signed [32:0] prod;
  logic               second;
  logic [2:0]         k;
  logic               hi;
  logic [2:0]         sidx;

  assign even_b = cur.data[{cnt, 1'b0}];
  assign odd_b  = cur.data[{cnt, 1'b1}];
  assign word   = {odd_b, even_b, 2'b00};
  assign prod   = word * $signed({1'b0, scale});
  assign second = (cnt >= tprd_pkg::SecondRecordWord);
  assign k      = second ? cnt - tprd_pkg::SecondRecordWord : cnt;
  assign hi     = second ? cur.hi2 : cur.hi1;
  assign sidx   = hi ? k + tprd_pkg::SecondRecordWord : k;

  assign pop       = (state == IDLE) && !q_empty;
  assign out_valid = (state == EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= 3'd0;
      scale <= tprd_pkg::ScaleReset;
      slots <= '0;
    end else begin
      if (cfg_we) begin
        scale <= cfg_wdata;
      end
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            cur   <= head;
            cnt   <= 3'd0;
            state <= RUN;
          end
        end
        RUN: begin
          slots[sidx] <= prod[31:0];
          cnt <= cnt + 3'd1;
          if (cnt == tprd_pkg::LastWord) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
